/* sv/ipq_pkg.sv */
// Shared types, codes and defaults for the indexed priority queue.
// No dependencies; imported by indexed_priority_queue.
package ipq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_SPACE_DEF = 256;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TOGGLE = 2'd2,
    OP_POP    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  // Heap entry: priority, takeaway flag, order id.
  typedef struct packed {
    logic [7:0] prio;
    logic       take;
    logic [7:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Smaller key is served first; takeaway set ranks ahead.
  function automatic logic [16:0] rank_key(entry_t e);
    rank_key = {e.prio, ~e.take, e.id};
  endfunction

endpackage

/* sv/ipq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/indexed_priority_queue.sv */
// Top level of the indexed priority queue: binary min-heap plus id-to-slot map.
// Depends on ipq_pkg and ipq_ram.
//
//   channel  ports                                        direction  handshake
//   in       in_opcode in_order_id in_priority_req         input      in_valid / in_stall
//            in_takeaway
//   out      out_status out_top_id out_top_priority        output     out_valid / out_stall
//            out_top_takeaway out_occupancy
//
// One request at a time. Rejected requests load the result register at the accept
// edge. Add, remove, toggle and pop take longer for each level that the entry climbs
// or descends, bound by the single read port of the heap memory.
// Reset clears the id valid bits and the entry count at once; no clearing pass.
// The result sits in an output register; a new request waits until it has drained.
module indexed_priority_queue
  import ipq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_order_id,
  input  logic [7:0] in_priority_req,
  input  logic       in_takeaway,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_top_id,
  output logic [7:0] out_top_priority,
  output logic       out_top_takeaway,
  output logic [6:0] out_occupancy
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(ID_SPACE);
  localparam int CW     = CNT_W + 1;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_SLOT_WAIT = 10'b0000000010,
    S_TOP_WAIT  = 10'b0000000100,
    S_LOAD_WAIT = 10'b0000001000,
    S_UP_CHK    = 10'b0000010000,
    S_UP_CMP    = 10'b0000100000,
    S_DN_L      = 10'b0001000000,
    S_DN_R      = 10'b0010000000,
    S_DN_CMP    = 10'b0100000000,
    S_FIN_WR    = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  entry_t              cur_r, cur_nxt;
  entry_t              lft_r, lft_nxt;
  logic                have_rgt_r, have_rgt_nxt;
  opcode_t             op_r, op_nxt;
  logic [ID_SPACE-1:0] valid_r, valid_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] status_r, status_nxt;
  entry_t     top_r, top_nxt;
  logic [6:0] occ_r, occ_nxt;

  // memory ports
  logic              heap_we;
  logic [SLOT_W-1:0] heap_waddr, heap_raddr;
  entry_t            heap_wdata, heap_rdata;
  logic              map_we;
  logic [IDX_W-1:0]  map_waddr, map_raddr;
  logic [SLOT_W-1:0] map_wdata, map_rdata;

  ipq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  ipq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Hold new requests while busy or while a result still waits in the register,
  // so a finishing request never overwrites an undrained result.
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  logic              accept;
  logic [IDX_W-1:0]  in_idx;
  logic              id_ok;
  logic [SLOT_W-1:0] last_slot;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CW-1:0]     left_w, right_w;
  logic [SLOT_W-1:0] parent;
  entry_t            best;
  logic [SLOT_W-1:0] best_pos;

  assign accept    = in_valid && !in_stall;
  assign in_idx    = IDX_W'(in_order_id);
  assign id_ok     = 32'(in_order_id) < ID_SPACE;
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign last_slot = SLOT_W'(cnt_dec);
  assign left_w    = (CW'(pos_r) << 1) + CW'(1);
  assign right_w   = left_w + CW'(1);
  assign parent    = (pos_r - SLOT_W'(1)) >> 1;

  // Pick the smallest of the moving entry and its children.
  always_comb begin
    best     = cur_r;
    best_pos = pos_r;
    if (rank_key(lft_r) < rank_key(best)) begin
      best     = lft_r;
      best_pos = left_w[SLOT_W-1:0];
    end
    if (have_rgt_r && (rank_key(heap_rdata) < rank_key(best))) begin
      best     = heap_rdata;
      best_pos = right_w[SLOT_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    lft_nxt       = lft_r;
    have_rgt_nxt  = have_rgt_r;
    op_nxt        = op_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    top_nxt       = top_r;
    occ_nxt       = occ_r;
    heap_we       = 1'b0;
    heap_waddr    = pos_r;
    heap_wdata    = cur_r;
    heap_raddr    = '0;
    map_we        = 1'b0;
    map_waddr     = IDX_W'(cur_r.id);
    map_wdata     = pos_r;
    map_raddr     = in_idx;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = opcode_t'(in_opcode);
          top_nxt = '0;
          unique case (opcode_t'(in_opcode))
            OP_ADD: begin
              if (!id_ok) begin
                status_nxt    = ST_NOTFOUND;
                occ_nxt       = 7'(cnt_r);
                out_valid_nxt = 1'b1;
              end else if (valid_r[in_idx]) begin
                status_nxt    = ST_DUP;
                occ_nxt       = 7'(cnt_r);
                out_valid_nxt = 1'b1;
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt    = ST_FULL;
                occ_nxt       = 7'(cnt_r);
                out_valid_nxt = 1'b1;
              end else begin
                cur_nxt           = '{prio: in_priority_req, take: in_takeaway,
                                      id: in_order_id};
                pos_nxt           = SLOT_W'(cnt_r);
                cnt_nxt           = cnt_r + CNT_W'(1);
                valid_nxt[in_idx] = 1'b1;
                state_nxt         = S_UP_CHK;
              end
            end
            OP_REMOVE, OP_TOGGLE: begin
              if (!id_ok || !valid_r[in_idx]) begin
                status_nxt    = ST_NOTFOUND;
                occ_nxt       = 7'(cnt_r);
                out_valid_nxt = 1'b1;
              end else begin
                if (opcode_t'(in_opcode) == OP_REMOVE) begin
                  valid_nxt[in_idx] = 1'b0;
                end
                state_nxt = S_SLOT_WAIT;
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                status_nxt    = ST_EMPTY;
                occ_nxt       = 7'(cnt_r);
                out_valid_nxt = 1'b1;
              end else begin
                heap_raddr = '0;
                state_nxt  = S_TOP_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SLOT_WAIT: begin
        pos_nxt = map_rdata;
        if (op_r == OP_TOGGLE) begin
          heap_raddr = map_rdata;
          state_nxt  = S_LOAD_WAIT;
        end else if (map_rdata != last_slot) begin
          heap_raddr = last_slot;
          cnt_nxt    = cnt_dec;
          state_nxt  = S_LOAD_WAIT;
        end else begin
          cnt_nxt       = cnt_dec;
          status_nxt    = ST_OK;
          occ_nxt       = 7'(cnt_dec);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TOP_WAIT: begin
        top_nxt                            = heap_rdata;
        valid_nxt[IDX_W'(heap_rdata.id)]   = 1'b0;
        cnt_nxt                            = cnt_dec;
        pos_nxt                            = '0;
        if (cnt_dec != '0) begin
          heap_raddr = last_slot;
          state_nxt  = S_LOAD_WAIT;
        end else begin
          status_nxt    = ST_OK;
          occ_nxt       = 7'(cnt_dec);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LOAD_WAIT: begin
        cur_nxt = heap_rdata;
        if (op_r == OP_TOGGLE) begin
          cur_nxt.take = ~heap_rdata.take;
        end
        state_nxt = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (pos_r == '0) begin
          state_nxt = S_DN_L;
        end else begin
          heap_raddr = parent;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // Move the parent down into the hole and climb.
        if (rank_key(cur_r) < rank_key(heap_rdata)) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          map_we     = 1'b1;
          map_waddr  = IDX_W'(heap_rdata.id);
          pos_nxt    = parent;
          state_nxt  = S_UP_CHK;
        end else begin
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        if (left_w < CW'(cnt_r)) begin
          heap_raddr = left_w[SLOT_W-1:0];
          state_nxt  = S_DN_R;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_DN_R: begin
        lft_nxt      = heap_rdata;
        have_rgt_nxt = right_w < CW'(cnt_r);
        heap_raddr   = right_w[SLOT_W-1:0];
        state_nxt    = S_DN_CMP;
      end
      S_DN_CMP: begin
        // Pull the smaller child up into the hole and descend.
        if (best_pos != pos_r) begin
          heap_we    = 1'b1;
          heap_wdata = best;
          map_we     = 1'b1;
          map_waddr  = IDX_W'(best.id);
          pos_nxt    = best_pos;
          state_nxt  = S_DN_L;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        heap_we       = 1'b1;
        map_we        = 1'b1;
        status_nxt    = ST_OK;
        occ_nxt       = 7'(cnt_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    lft_r      <= lft_nxt;
    have_rgt_r <= have_rgt_nxt;
    op_r       <= op_nxt;
    status_r   <= status_nxt;
    top_r      <= top_nxt;
    occ_r      <= occ_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_top_id       = top_r.id;
  assign out_top_priority = top_r.prio;
  assign out_top_takeaway = top_r.take;
  assign out_occupancy    = occ_r;

endmodule
